// File: rtl/core/lcsd_pkg.sv
`timescale 1ns / 1ps

package lcsd_pkg;

    // series geometry
    localparam int SERIES_LENGTH = 20;
    localparam int CNT_W         = $clog2(SERIES_LENGTH + 1);
    localparam int SUM_W         = 24 + $clog2(SERIES_LENGTH);

    // truncating divide by SERIES_LENGTH: reciprocal multiply, one correction step
    localparam logic [SUM_W-1:0] DIV_RECIP = SUM_W'((64'd1 << SUM_W) / SERIES_LENGTH);

    // event queue between front and back
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    // config port
    localparam int ADDR_W = 5;
    localparam int DATA_W = 32;

    localparam logic [2:0] REG_PRESENCE_THR = 3'd0;
    localparam logic [2:0] REG_SAMPLE_TOL   = 3'd1;
    localparam logic [2:0] REG_WEIGHT_TOL   = 3'd2;
    localparam logic [2:0] REG_ABSENCE_MIN  = 3'd3;
    localparam logic [2:0] REG_ABSENCE_LIM  = 3'd4;

    localparam logic signed [23:0] PRESENCE_THR_RST = 24'sd50000;
    localparam logic [23:0]        SAMPLE_TOL_RST   = 24'd1000;
    localparam logic [23:0]        WEIGHT_TOL_RST   = 24'd50;
    localparam logic [7:0]         ABSENCE_MIN_RST  = 8'd10;
    localparam logic [7:0]         ABSENCE_LIM_RST  = 8'd100;
    localparam logic [23:0]        BEST_SPREAD_RST  = 24'd1000;

    // result status codes
    localparam logic [1:0] ST_LEFT      = 2'd0;
    localparam logic [1:0] ST_UNSTABLE  = 2'd1;
    localparam logic [1:0] ST_STABLE    = 2'd2;
    localparam logic [1:0] ST_CAME_BACK = 2'd3;

    // queue event codes
    localparam logic [1:0] EV_NONE = 2'd0;   // best restart only, no result
    localparam logic [1:0] EV_LEFT = 2'd1;
    localparam logic [1:0] EV_BACK = 2'd2;
    localparam logic [1:0] EV_DONE = 2'd3;

    typedef struct packed {
        logic signed [23:0] presence_threshold;
        logic [23:0]        dev_limit;
        logic [23:0]        stable_limit;
        logic [7:0]         absence_min;
        logic [7:0]         absence_limit;
    } cfg_t;

    typedef struct packed {
        logic [1:0]              evt;
        logic                    restart;
        logic signed [SUM_W-1:0] sum;
        logic signed [23:0]      min_val;
        logic signed [23:0]      max_val;
    } evt_t;

endpackage

// File: rtl/core/load_cell_stability_detector.sv
`timescale 1ns / 1ps

// Load-cell stability detector. Accepts one averaged sample per clock with no gap
// while the result side keeps up. The front end tracks presence, absence and the
// running sum/min/max of a series combinationally, registering it as each sample
// is accepted, and posts one event per sample that ends a series or restarts the
// best value into a four-entry queue. The back end works events through a
// three-stage divide-by-series-length (reciprocal multiply plus one correction) and
// best tracking, whose result is registered onto the m_ port.
// A stalled result side stops the back end only; the front keeps taking samples
// until the queue is full. Configuration writes are meant for idle periods.
// Note: m_best_average / m_best_spread_out hold the best values after the
// transfer's own sample, and stay valid with the rest of the result.

module load_cell_stability_detector (
    input  logic                        aclk,
    input  logic                        aresetn,
    // config
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [lcsd_pkg::ADDR_W-1:0] paddr,
    input  logic [lcsd_pkg::DATA_W-1:0] pwdata,
    output logic [lcsd_pkg::DATA_W-1:0] prdata,
    output logic                        pready,
    // samples in
    input  logic                        s_valid,
    output logic                        s_ready,
    input  logic signed [23:0]          s_sample_value,
    input  logic [23:0]                 s_sample_deviation,
    input  logic                        s_series_start,
    input  logic                        s_series_mode,
    input  logic                        s_restart_best,
    // results out
    output logic                        m_valid,
    input  logic                        m_ready,
    output logic [1:0]                  m_series_status,
    output logic signed [23:0]          m_series_average,
    output logic [23:0]                 m_series_spread,
    output logic signed [23:0]          m_best_average,
    output logic [23:0]                 m_best_spread_out
);
    import lcsd_pkg::*;

    cfg_t cfg;
    evt_t push_entry, q_head;
    logic q_push, q_pop, q_full, q_empty;

    lcsd_cfg u_cfg (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    lcsd_front u_front (
        .aclk               (aclk),
        .aresetn            (aresetn),
        .cfg                (cfg),
        .s_valid            (s_valid),
        .s_ready            (s_ready),
        .s_sample_value     (s_sample_value),
        .s_sample_deviation (s_sample_deviation),
        .s_series_start     (s_series_start),
        .s_series_mode      (s_series_mode),
        .s_restart_best     (s_restart_best),
        .q_full             (q_full),
        .q_push             (q_push),
        .q_entry            (push_entry)
    );

    lcsd_queue u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (q_push),
        .push_entry (push_entry),
        .pop        (q_pop),
        .head       (q_head),
        .full       (q_full),
        .empty      (q_empty)
    );

    lcsd_back u_back (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .cfg               (cfg),
        .q_head            (q_head),
        .q_empty           (q_empty),
        .q_pop             (q_pop),
        .m_valid           (m_valid),
        .m_ready           (m_ready),
        .m_series_status   (m_series_status),
        .m_series_average  (m_series_average),
        .m_series_spread   (m_series_spread),
        .m_best_average    (m_best_average),
        .m_best_spread_out (m_best_spread_out)
    );

endmodule

// File: rtl/core/lcsd_cfg.sv
`timescale 1ns / 1ps

module lcsd_cfg (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [lcsd_pkg::ADDR_W-1:0] paddr,
    input  logic [lcsd_pkg::DATA_W-1:0] pwdata,
    output logic [lcsd_pkg::DATA_W-1:0] prdata,
    output logic                       pready,
    output lcsd_pkg::cfg_t             cfg
);
    import lcsd_pkg::*;

    cfg_t       cfg_reg;
    logic [2:0] reg_idx;
    logic       wr_en;

    assign reg_idx = paddr[ADDR_W-1:2];
    assign wr_en   = psel & penable & pwrite;
    assign pready  = 1'b1;
    assign cfg     = cfg_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.presence_threshold <= PRESENCE_THR_RST;
            cfg_reg.dev_limit          <= SAMPLE_TOL_RST;
            cfg_reg.stable_limit       <= WEIGHT_TOL_RST;
            cfg_reg.absence_min        <= ABSENCE_MIN_RST;
            cfg_reg.absence_limit      <= ABSENCE_LIM_RST;
        end else if (wr_en) begin
            case (reg_idx)
                REG_PRESENCE_THR: cfg_reg.presence_threshold <= pwdata[23:0];
                REG_SAMPLE_TOL:   cfg_reg.dev_limit          <= pwdata[23:0];
                REG_WEIGHT_TOL:   cfg_reg.stable_limit       <= pwdata[23:0];
                REG_ABSENCE_MIN:  cfg_reg.absence_min        <= pwdata[7:0];
                REG_ABSENCE_LIM:  cfg_reg.absence_limit      <= pwdata[7:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (reg_idx)
            REG_PRESENCE_THR: prdata = {8'd0, cfg_reg.presence_threshold};
            REG_SAMPLE_TOL:   prdata = {8'd0, cfg_reg.dev_limit};
            REG_WEIGHT_TOL:   prdata = {8'd0, cfg_reg.stable_limit};
            REG_ABSENCE_MIN:  prdata = {24'd0, cfg_reg.absence_min};
            REG_ABSENCE_LIM:  prdata = {24'd0, cfg_reg.absence_limit};
            default:          prdata = '0;
        endcase
    end

endmodule

// File: rtl/core/lcsd_front.sv
`timescale 1ns / 1ps

module lcsd_front (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  lcsd_pkg::cfg_t            cfg,
    input  logic                      s_valid,
    output logic                      s_ready,
    input  logic signed [23:0]        s_sample_value,
    input  logic [23:0]               s_sample_deviation,
    input  logic                      s_series_start,
    input  logic                      s_series_mode,
    input  logic                      s_restart_best,
    input  logic                      q_full,
    output logic                      q_push,
    output lcsd_pkg::evt_t            q_entry
);
    import lcsd_pkg::*;

    logic                    active_reg, active_next;
    logic                    offset_reg, offset_next;
    logic [8:0]              absence_reg, absence_next;
    logic [CNT_W-1:0]        count_reg, count_next;
    logic signed [SUM_W-1:0] sum_reg, sum_next;
    logic signed [23:0]      min_reg, min_next;
    logic signed [23:0]      max_reg, max_next;

    logic                    accept;
    logic                    act_e, off_e;
    logic [CNT_W-1:0]        cnt_e, cnt_inc;
    logic signed [SUM_W-1:0] sum_e, sum_add;
    logic [8:0]              absence_inc;
    logic [1:0]              evt;

    assign s_ready = ~q_full;
    assign accept  = s_valid & s_ready;

    always_comb begin
        // a start clears the series before the sample is looked at
        act_e = s_series_start | active_reg;
        off_e = s_series_start ? s_series_mode : offset_reg;
        cnt_e = s_series_start ? '0 : count_reg;
        sum_e = s_series_start ? '0 : sum_reg;

        active_next  = act_e;
        offset_next  = off_e;
        absence_next = absence_reg;
        count_next   = cnt_e;
        sum_next     = sum_e;
        min_next     = s_series_start ? '0 : min_reg;
        max_next     = s_series_start ? '0 : max_reg;
        evt          = EV_NONE;

        absence_inc = absence_reg + 9'd1;
        cnt_inc     = cnt_e + CNT_W'(1);
        sum_add     = sum_e + SUM_W'(s_sample_value);

        if (act_e) begin
            if (s_sample_value < cfg.presence_threshold) begin
                if (absence_inc > {1'b0, cfg.absence_limit}) begin
                    absence_next = '0;
                    active_next  = 1'b0;
                    evt          = EV_LEFT;
                end else begin
                    absence_next = absence_inc;
                    if (absence_inc > {1'b0, cfg.absence_min}) begin
                        offset_next = 1'b1;
                    end
                end
            end else begin
                absence_next = '0;
                if (off_e) begin
                    active_next = 1'b0;
                    evt         = EV_BACK;
                end else if (s_sample_deviation <= cfg.dev_limit) begin
                    if (cnt_e == '0) begin
                        min_next = s_sample_value;
                        max_next = s_sample_value;
                    end else begin
                        if (s_sample_value < min_reg) min_next = s_sample_value;
                        if (s_sample_value > max_reg) max_next = s_sample_value;
                    end
                    sum_next   = sum_add;
                    count_next = cnt_inc;
                    if (cnt_inc == CNT_W'(SERIES_LENGTH)) begin
                        active_next = 1'b0;
                        count_next  = '0;
                        evt         = EV_DONE;
                    end
                end
            end
        end

        q_entry.evt     = evt;
        q_entry.restart = s_restart_best;
        q_entry.sum     = sum_next;
        q_entry.min_val = min_next;
        q_entry.max_val = max_next;
        q_push          = accept & (s_restart_best | (evt != EV_NONE));
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            active_reg  <= 1'b0;
            offset_reg  <= 1'b0;
            absence_reg <= '0;
            count_reg   <= '0;
            sum_reg     <= '0;
            min_reg     <= '0;
            max_reg     <= '0;
        end else if (accept) begin
            active_reg  <= active_next;
            offset_reg  <= offset_next;
            absence_reg <= absence_next;
            count_reg   <= count_next;
            sum_reg     <= sum_next;
            min_reg     <= min_next;
            max_reg     <= max_next;
        end
    end

endmodule

// File: rtl/core/lcsd_queue.sv
`timescale 1ns / 1ps

module lcsd_queue (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           push,
    input  lcsd_pkg::evt_t push_entry,
    input  logic           pop,
    output lcsd_pkg::evt_t head,
    output logic           full,
    output logic           empty
);
    import lcsd_pkg::*;

    evt_t              mem_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [QCNT_W-1:0] cnt_reg;

    assign full  = (cnt_reg == QCNT_W'(QUEUE_DEPTH));
    assign empty = (cnt_reg == '0);
    assign head  = mem_reg[rd_ptr_reg];

    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wr_ptr_reg] <= push_entry;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end else begin
            if (push) wr_ptr_reg <= wr_ptr_reg + QPTR_W'(1);
            if (pop)  rd_ptr_reg <= rd_ptr_reg + QPTR_W'(1);
            case ({push, pop})
                2'b10:   cnt_reg <= cnt_reg + QCNT_W'(1);
                2'b01:   cnt_reg <= cnt_reg - QCNT_W'(1);
                default: cnt_reg <= cnt_reg;
            endcase
        end
    end

endmodule

// File: rtl/core/lcsd_back.sv
`timescale 1ns / 1ps

module lcsd_back (
    input  logic               aclk,
    input  logic               aresetn,
    input  lcsd_pkg::cfg_t     cfg,
    input  lcsd_pkg::evt_t     q_head,
    input  logic               q_empty,
    output logic               q_pop,
    output logic               m_valid,
    input  logic               m_ready,
    output logic [1:0]         m_series_status,
    output logic signed [23:0] m_series_average,
    output logic [23:0]        m_series_spread,
    output logic signed [23:0] m_best_average,
    output logic [23:0]        m_best_spread_out
);
    import lcsd_pkg::*;

    // stage 1: magnitude and spread
    logic               p1_v_reg;
    logic [1:0]         p1_evt_reg;
    logic               p1_rst_reg, p1_neg_reg;
    logic [SUM_W-1:0]   p1_abs_reg;
    logic [23:0]        p1_spread_reg;
    // stage 2: reciprocal product
    logic               p2_v_reg;
    logic [1:0]         p2_evt_reg;
    logic               p2_rst_reg, p2_neg_reg;
    logic [SUM_W-1:0]   p2_abs_reg;
    logic [2*SUM_W-1:0] p2_prod_reg;
    logic [23:0]        p2_spread_reg;
    // stage 3: corrected quotient
    logic               p3_v_reg;
    logic [1:0]         p3_evt_reg;
    logic               p3_rst_reg;
    logic signed [23:0] p3_avg_reg;
    logic [23:0]        p3_spread_reg;
    // best tracking and output
    logic signed [23:0] best_w_reg, best_w_next;
    logic [23:0]        best_s_reg, best_s_next;
    logic               m_valid_reg, m_valid_next;
    logic [1:0]         status_reg, status_next;
    logic signed [23:0] avg_out_reg;
    logic [23:0]        spread_out_reg;
    logic signed [23:0] best_avg_out_reg;
    logic [23:0]        best_spr_out_reg;

    logic               p1_rdy, p2_rdy, p3_rdy, p3_go, out_free;
    logic               head_neg;
    logic [SUM_W-1:0]   head_abs;
    logic [SUM_W-1:0]   q_est, q_times_n, rem, q_fix;
    logic [23:0]        q_mag;

    assign out_free = ~m_valid_reg | m_ready;
    assign p3_go    = p3_v_reg & ((p3_evt_reg == EV_NONE) | out_free);
    assign p3_rdy   = ~p3_v_reg | p3_go;
    assign p2_rdy   = ~p2_v_reg | p3_rdy;
    assign p1_rdy   = ~p1_v_reg | p2_rdy;
    assign q_pop    = ~q_empty & p1_rdy;

    assign head_neg = q_head.sum[SUM_W-1];
    assign head_abs = head_neg ? SUM_W'(-q_head.sum) : SUM_W'(q_head.sum);

    // estimate is low by at most one
    assign q_est     = p2_prod_reg[2*SUM_W-1:SUM_W];
    assign q_times_n = SUM_W'(q_est * SUM_W'(SERIES_LENGTH));
    assign rem       = p2_abs_reg - q_times_n;
    assign q_fix     = (rem >= SUM_W'(SERIES_LENGTH)) ? q_est + SUM_W'(1) : q_est;
    assign q_mag     = q_fix[23:0];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            p1_v_reg <= 1'b0;
            p2_v_reg <= 1'b0;
            p3_v_reg <= 1'b0;
        end else begin
            if (p1_rdy) p1_v_reg <= q_pop;
            if (p2_rdy) p2_v_reg <= p1_v_reg;
            if (p3_rdy) p3_v_reg <= p2_v_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (q_pop) begin
            p1_evt_reg    <= q_head.evt;
            p1_rst_reg    <= q_head.restart;
            p1_neg_reg    <= head_neg;
            p1_abs_reg    <= head_abs;
            p1_spread_reg <= 24'(q_head.max_val - q_head.min_val);
        end
        if (p2_rdy && p1_v_reg) begin
            p2_evt_reg    <= p1_evt_reg;
            p2_rst_reg    <= p1_rst_reg;
            p2_neg_reg    <= p1_neg_reg;
            p2_abs_reg    <= p1_abs_reg;
            p2_prod_reg   <= p1_abs_reg * DIV_RECIP;
            p2_spread_reg <= p1_spread_reg;
        end
        if (p3_rdy && p2_v_reg) begin
            p3_evt_reg    <= p2_evt_reg;
            p3_rst_reg    <= p2_rst_reg;
            p3_avg_reg    <= p2_neg_reg ? -q_mag : q_mag;
            p3_spread_reg <= p2_spread_reg;
        end
    end

    always_comb begin
        best_w_next  = best_w_reg;
        best_s_next  = best_s_reg;
        m_valid_next = m_valid_reg & ~m_ready;
        status_next  = ST_LEFT;
        if (p3_rst_reg) begin
            best_w_next = '0;
            best_s_next = cfg.dev_limit;
        end
        case (p3_evt_reg)
            EV_LEFT: status_next = ST_LEFT;
            EV_BACK: status_next = ST_CAME_BACK;
            EV_DONE: begin
                status_next = (p3_spread_reg < cfg.stable_limit) ? ST_STABLE : ST_UNSTABLE;
                if (p3_spread_reg < best_s_next) begin
                    best_w_next = p3_avg_reg;
                    best_s_next = p3_spread_reg;
                end
            end
            default: status_next = ST_LEFT;
        endcase
        if (p3_go && p3_evt_reg != EV_NONE) begin
            m_valid_next = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            best_w_reg  <= '0;
            best_s_reg  <= BEST_SPREAD_RST;
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
            if (p3_go) begin
                best_w_reg <= best_w_next;
                best_s_reg <= best_s_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (p3_go && p3_evt_reg != EV_NONE) begin
            status_reg       <= status_next;
            avg_out_reg      <= (p3_evt_reg == EV_DONE) ? p3_avg_reg : '0;
            spread_out_reg   <= (p3_evt_reg == EV_DONE) ? p3_spread_reg : '0;
            best_avg_out_reg <= best_w_next;
            best_spr_out_reg <= best_s_next;
        end
    end

    assign m_valid           = m_valid_reg;
    assign m_series_status   = status_reg;
    assign m_series_average  = avg_out_reg;
    assign m_series_spread   = spread_out_reg;
    // best values are those current when the result was formed
    assign m_best_average    = best_avg_out_reg;
    assign m_best_spread_out = best_spr_out_reg;

endmodule

// File: tb/sv/testbench.sv
`timescale 1ns / 1ps

module testbench;
    import lcsd_pkg::*;

    localparam int IDLE_LIMIT   = 4000;
    localparam int SETTLE_WAIT  = 30;
    localparam int PHASE_ITEMS  = 200;
    localparam int HOLD_CYCLES  = 400;

    typedef struct packed {
        logic signed [23:0] level;
        logic [23:0]        dev;
        logic               start;
        logic               mode;
        logic               restart;
    } sample_t;

    typedef struct packed {
        logic [1:0]         status;
        logic signed [23:0] avg;
        logic [23:0]        spread;
        logic signed [23:0] best_avg;
        logic [23:0]        best_spread;
    } series_result_t;

    typedef struct packed {
        sample_t        smp;
        logic           fixed;
        series_result_t res;
    } stim_row_t;

    // ports
    logic                  aclk = 1'b0;
    logic                  aresetn = 1'b0;
    logic                  psel = 1'b0;
    logic                  penable = 1'b0;
    logic                  pwrite = 1'b0;
    logic [ADDR_W-1:0]     paddr = '0;
    logic [DATA_W-1:0]     pwdata = '0;
    logic [DATA_W-1:0]     prdata;
    logic                  pready;
    logic                  s_valid = 1'b0;
    logic                  s_ready;
    logic signed [23:0]    s_sample_value = '0;
    logic [23:0]           s_sample_deviation = '0;
    logic                  s_series_start = 1'b0;
    logic                  s_series_mode = 1'b0;
    logic                  s_restart_best = 1'b0;
    logic                  m_valid;
    logic                  m_ready = 1'b0;
    logic [1:0]            m_series_status;
    logic signed [23:0]    m_series_average;
    logic [23:0]           m_series_spread;
    logic signed [23:0]    m_best_average;
    logic [23:0]           m_best_spread_out;

    // sideband that travels with the driven sample: typed expectation for table rows
    logic                  row_fixed = 1'b0;
    series_result_t        row_fixed_res = '0;

    // predictor copy of configuration and state
    logic signed [23:0]    cfg_thr = PRESENCE_THR_RST;
    logic [23:0]           cfg_stol = SAMPLE_TOL_RST;
    logic [23:0]           cfg_wtol = WEIGHT_TOL_RST;
    logic [7:0]            cfg_amin = ABSENCE_MIN_RST;
    logic [7:0]            cfg_alim = ABSENCE_LIM_RST;
    logic                  ser_active = 1'b0;
    logic                  ser_offset = 1'b0;
    logic [8:0]            absent_cnt = '0;
    int                    rec_cnt = 0;
    longint                run_sum = 0;
    int                    run_min = 0;
    int                    run_max = 0;
    logic signed [23:0]    best_w = '0;
    logic [23:0]           best_sp = BEST_SPREAD_RST;

    series_result_t        pending_results[$];
    int                    mismatches = 0;

    // traffic shaping
    int                    send_idle_pct = 0;
    int                    recv_stall_pct = 0;
    int                    hold_req = 0;
    int                    hold_left = 0;
    int                    idle_cycles = 0;

    // series generator state
    int                    seq_left = 0;
    int                    absent_left = 0;
    longint                ser_base = 0;
    longint                ser_jit = 0;

    load_cell_stability_detector dut (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .psel              (psel),
        .penable           (penable),
        .pwrite            (pwrite),
        .paddr             (paddr),
        .pwdata            (pwdata),
        .prdata            (prdata),
        .pready            (pready),
        .s_valid           (s_valid),
        .s_ready           (s_ready),
        .s_sample_value    (s_sample_value),
        .s_sample_deviation(s_sample_deviation),
        .s_series_start    (s_series_start),
        .s_series_mode     (s_series_mode),
        .s_restart_best    (s_restart_best),
        .m_valid           (m_valid),
        .m_ready           (m_ready),
        .m_series_status   (m_series_status),
        .m_series_average  (m_series_average),
        .m_series_spread   (m_series_spread),
        .m_best_average    (m_best_average),
        .m_best_spread_out (m_best_spread_out)
    );

    always begin
        #6 aclk = 1'b1;
        #6 aclk = 1'b0;
    end

    function automatic series_result_t pack_result(input logic [1:0] status,
                                                   input longint avg, input longint spread);
        series_result_t r;
        r.status      = status;
        r.avg         = 24'(avg);
        r.spread      = 24'(spread);
        r.best_avg    = best_w;
        r.best_spread = best_sp;
        return r;
    endfunction

    // one sample through the detector; returns 1 when it ends a series
    function automatic bit predict_series(input sample_t smp, output series_result_t res);
        int     val;
        longint avg;
        longint spread;
        logic [1:0] status;
        res = '0;
        val = int'(smp.level);
        if (smp.restart) begin
            best_w  = '0;
            best_sp = cfg_stol;
        end
        if (smp.start) begin
            ser_active = 1'b1;
            ser_offset = smp.mode;
            rec_cnt    = 0;
            run_sum    = 0;
            run_min    = 0;
            run_max    = 0;
        end
        if (!ser_active)
            return 1'b0;
        if (val < int'(cfg_thr)) begin
            absent_cnt = absent_cnt + 9'd1;
            if (absent_cnt > {1'b0, cfg_alim}) begin
                absent_cnt = '0;
                ser_active = 1'b0;
                res = pack_result(ST_LEFT, 0, 0);
                return 1'b1;
            end
            if (absent_cnt > {1'b0, cfg_amin})
                ser_offset = 1'b1;
            return 1'b0;
        end
        absent_cnt = '0;
        if (ser_offset) begin
            ser_active = 1'b0;
            res = pack_result(ST_CAME_BACK, 0, 0);
            return 1'b1;
        end
        if (smp.dev > cfg_stol)
            return 1'b0;
        if (rec_cnt == 0) begin
            run_min = val;
            run_max = val;
        end else begin
            if (val < run_min) run_min = val;
            if (val > run_max) run_max = val;
        end
        run_sum += val;
        rec_cnt++;
        if (rec_cnt < SERIES_LENGTH)
            return 1'b0;
        avg    = run_sum / SERIES_LENGTH;
        spread = longint'(run_max) - longint'(run_min);
        if (spread < longint'(best_sp)) begin
            best_w  = 24'(avg);
            best_sp = 24'(spread);
        end
        status = (spread < longint'(cfg_wtol)) ? ST_STABLE : ST_UNSTABLE;
        ser_active = 1'b0;
        rec_cnt    = 0;
        res = pack_result(status, avg, spread);
        return 1'b1;
    endfunction

    function automatic longint sat24(input longint v);
        if (v > 64'sd8388607) return 64'sd8388607;
        if (v < -64'sd8388608) return -64'sd8388608;
        return v;
    endfunction

    // mostly well-formed series: start, present samples around a base, absence runs
    function automatic sample_t next_sample();
        sample_t s;
        longint  thr;
        longint  v;
        thr = longint'(cfg_thr);
        s = '0;
        if ($urandom_range(19) == 0) begin
            s.level   = 24'($urandom);
            s.dev     = 24'($urandom);
            s.start   = 1'($urandom_range(1));
            s.mode    = 1'($urandom_range(1));
            s.restart = 1'($urandom_range(1));
            return s;
        end
        s.mode = 1'($urandom_range(1));
        if (seq_left <= 0) begin
            s.start  = 1'b1;
            s.mode   = ($urandom_range(7) == 0);
            seq_left = $urandom_range(28, 18);
            if ($urandom_range(5) == 0)
                ser_base = sat24(thr + longint'($urandom_range(16777215)));
            else
                ser_base = sat24(thr + longint'($urandom_range(5000)));
            case ($urandom_range(3))
                0: ser_jit = 0;
                1: ser_jit = longint'(cfg_wtol) / 2;
                2: ser_jit = longint'(cfg_wtol) * 2 + 1;
                default: ser_jit = longint'($urandom_range(16777215));
            endcase
            if (ser_jit > 64'sd33554431) ser_jit = 64'sd33554431;
        end
        seq_left--;
        if (absent_left == 0 && thr > -64'sd8388608 && $urandom_range(19) == 0)
            absent_left = $urandom_range(int'(cfg_alim) + 3, 1);
        if (absent_left > 0) begin
            absent_left--;
            if ($urandom_range(3) == 0)
                v = -64'sd8388608 + longint'($urandom_range(32'(thr + 8388607)));
            else
                v = thr - 1 - longint'($urandom_range(1000));
            if (v < -64'sd8388608) v = -64'sd8388608;
            if (absent_left == 0 && $urandom_range(1) == 0)
                seq_left = 0;
        end else begin
            v = sat24(ser_base + longint'($urandom_range(32'(ser_jit))));
        end
        s.level = 24'(v);
        if ($urandom_range(7) == 0)
            s.dev = 24'(longint'(cfg_stol) + 1 + longint'($urandom_range(1000)));
        else
            s.dev = 24'($urandom_range(32'(cfg_stol)));
        s.restart = ($urandom_range(24) == 0);
        if (!s.start && $urandom_range(49) == 0) begin
            s.start = 1'b1;
            s.mode  = ($urandom_range(3) == 0);
        end
        return s;
    endfunction

    function automatic stim_row_t dir_row(input int level, input int dev, input bit start,
                                          input bit mode, input bit restart, input bit fixed,
                                          input logic [1:0] status, input int best_s);
        stim_row_t r;
        r.smp.level           = 24'(level);
        r.smp.dev             = 24'(dev);
        r.smp.start           = start;
        r.smp.mode            = mode;
        r.smp.restart         = restart;
        r.fixed               = fixed;
        r.res.status          = status;
        r.res.avg             = '0;
        r.res.spread          = '0;
        r.res.best_avg        = '0;
        r.res.best_spread     = 24'(best_s);
        return r;
    endfunction

    task automatic reg_write(input logic [2:0] idx, input logic [31:0] data);
        @(posedge aclk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= data;
        @(posedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (idx)
            REG_PRESENCE_THR: cfg_thr  = data[23:0];
            REG_SAMPLE_TOL:   cfg_stol = data[23:0];
            REG_WEIGHT_TOL:   cfg_wtol = data[23:0];
            REG_ABSENCE_MIN:  cfg_amin = data[7:0];
            REG_ABSENCE_LIM:  cfg_alim = data[7:0];
            default: ;
        endcase
    endtask

    task automatic apply_config(input logic [23:0] thr, input logic [23:0] stol,
                                input logic [23:0] wtol, input logic [7:0] amin,
                                input logic [7:0] alim);
        reg_write(REG_PRESENCE_THR, {8'd0, thr});
        reg_write(REG_SAMPLE_TOL, {8'd0, stol});
        reg_write(REG_WEIGHT_TOL, {8'd0, wtol});
        reg_write(REG_ABSENCE_MIN, {24'd0, amin});
        reg_write(REG_ABSENCE_LIM, {24'd0, alim});
    endtask

    task automatic send_sample(input sample_t smp, input logic fixed,
                               input series_result_t fres);
        while ($urandom_range(99) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid            <= 1'b1;
        s_sample_value     <= smp.level;
        s_sample_deviation <= smp.dev;
        s_series_start     <= smp.start;
        s_series_mode      <= smp.mode;
        s_restart_best     <= smp.restart;
        row_fixed          <= fixed;
        row_fixed_res      <= fres;
        do @(posedge aclk); while (!s_ready);
    endtask

    // wait for every expected result, then let queued restart events work through
    task automatic settle();
        while (pending_results.size() != 0)
            @(posedge aclk);
        repeat (SETTLE_WAIT) @(posedge aclk);
    endtask

    // receiver: random stalls, plus a long hold-off counted here
    always @(posedge aclk) begin
        if (hold_req != 0) begin
            hold_left = hold_req;
            hold_req  = 0;
        end
        if (hold_left > 0) begin
            m_ready <= 1'b0;
            hold_left--;
        end else begin
            m_ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    always @(posedge aclk) begin : monitor
        series_result_t predicted;
        series_result_t want;
        series_result_t seen;
        bit             produced;
        if (aresetn) begin
            if (s_valid && s_ready) begin
                produced = predict_series({s_sample_value, s_sample_deviation, s_series_start,
                                           s_series_mode, s_restart_best}, predicted);
                if (row_fixed)
                    pending_results.push_back(row_fixed_res);
                else if (produced)
                    pending_results.push_back(predicted);
            end
            if (m_valid && m_ready) begin
                seen = {m_series_status, m_series_average, m_series_spread,
                        m_best_average, m_best_spread_out};
                if (pending_results.size() == 0) begin
                    if (mismatches < 10)
                        $display("unexpected result: st=%0d avg=%0d spr=%0d best=%0d/%0d",
                                 seen.status, seen.avg, seen.spread, seen.best_avg,
                                 seen.best_spread);
                    mismatches++;
                end else begin
                    want = pending_results.pop_front();
                    if (seen !== want) begin
                        if (mismatches < 10)
                            $display({"mismatch: want st=%0d avg=%0d spr=%0d best=%0d/%0d",
                                      " got st=%0d avg=%0d spr=%0d best=%0d/%0d"},
                                     want.status, want.avg, want.spread, want.best_avg,
                                     want.best_spread, seen.status, seen.avg, seen.spread,
                                     seen.best_avg, seen.best_spread);
                        mismatches++;
                    end
                end
            end
        end
    end

    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready) || (psel && penable))
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("tb: failure");
            $finish;
        end
    end

    initial begin : main
        stim_row_t dir_tbl[$];
        int        p;
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;

        // directed: short absence limits so left and came back show within a few rows
        apply_config(24'd0, 24'd100, 24'd50, 8'd1, 8'd2);
        // no active series: ignored
        dir_tbl.push_back(dir_row(8388607, 16777215, 0, 1, 0, 0, ST_LEFT, 0));
        // offset mode at start, present sample ends it at once
        dir_tbl.push_back(dir_row(5, 0, 1, 1, 0, 1, ST_CAME_BACK, 1000));
        dir_tbl.push_back(dir_row(-8388608, 0, 1, 0, 0, 0, ST_LEFT, 0));
        dir_tbl.push_back(dir_row(-1, 0, 0, 0, 0, 0, ST_LEFT, 0));
        // restart takes effect before the absence that ends the series
        dir_tbl.push_back(dir_row(-5, 0, 0, 0, 1, 1, ST_LEFT, 100));
        dir_tbl.push_back(dir_row(8388607, 100, 1, 0, 0, 0, ST_LEFT, 0));
        // start over an active series drops it; deviation over tolerance skipped
        dir_tbl.push_back(dir_row(1000, 101, 1, 0, 0, 0, ST_LEFT, 0));
        for (int i = 0; i < SERIES_LENGTH; i++)
            dir_tbl.push_back(dir_row(1000 + (i * 7) % 40, (i == SERIES_LENGTH - 1) ? 100 : i * 5,
                                      0, 1'(i % 2), 0, 0, ST_LEFT, 0));
        foreach (dir_tbl[i])
            send_sample(dir_tbl[i].smp, dir_tbl[i].fixed, dir_tbl[i].res);
        s_valid <= 1'b0;
        settle();

        for (p = 0; p < 8; p++) begin
            case (p)
                0: begin
                    apply_config(24'd50000, 24'd1000, 24'd50, 8'd10, 8'd100);
                    send_idle_pct = 0;  recv_stall_pct = 0;
                end
                1: begin
                    apply_config(24'd0, 24'd200, 24'd30, 8'd3, 8'd8);
                    send_idle_pct = 70; recv_stall_pct = 0;
                end
                2: begin
                    apply_config(24'h800000, 24'hFFFFFF, 24'hFFFFFF, 8'd255, 8'd255);
                    send_idle_pct = 0;  recv_stall_pct = 70;
                end
                3: begin
                    apply_config(24'h7FFFFF, 24'd0, 24'd0, 8'd0, 8'd0);
                    send_idle_pct = 16; recv_stall_pct = 16;
                end
                4: begin
                    apply_config(-24'sd1000, 24'd500, 24'd100, 8'd2, 8'd5);
                    send_idle_pct = 0;  recv_stall_pct = 0;
                    hold_req = HOLD_CYCLES;
                end
                5: begin
                    apply_config(24'($urandom), 24'($urandom), 24'($urandom),
                                 8'($urandom), 8'($urandom));
                    send_idle_pct = 16; recv_stall_pct = 16;
                end
                6: begin
                    apply_config(24'($urandom), 24'($urandom_range(5000)),
                                 24'($urandom_range(500)), 8'($urandom_range(20)),
                                 8'($urandom_range(40)));
                    send_idle_pct = 70; recv_stall_pct = 0;
                end
                default: begin
                    apply_config(24'd50000, 24'd1000, 24'd50, 8'd10, 8'd100);
                    send_idle_pct = 0;  recv_stall_pct = 70;
                end
            endcase
            seq_left    = 0;
            absent_left = 0;
            repeat (PHASE_ITEMS) send_sample(next_sample(), 1'b0, '0);
            s_valid <= 1'b0;
            settle();
        end

        if (mismatches == 0 && pending_results.size() == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule

// File: files.f
rtl/core/lcsd_pkg.sv
rtl/core/lcsd_cfg.sv
rtl/core/lcsd_front.sv
rtl/core/lcsd_queue.sv
rtl/core/lcsd_back.sv
rtl/core/load_cell_stability_detector.sv
tb/sv/testbench.sv
